FILE: rtl/core/cqit_pkg.sv
// cqit_pkg: shared types, constants and helpers of the cigar query interval trimmer
// depends on nothing; used by every file of the block except cqit_ram
package cqit_pkg;

  // pending store of non-query operations
  localparam int unsigned PENDING_DEPTH = 8;
  localparam int unsigned PendIdxW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned PendCntW = $clog2(PENDING_DEPTH + 1);

  // field widths
  localparam int unsigned CodeW   = 4;
  localparam int unsigned LenW    = 28;
  localparam int unsigned RegW    = 31;
  localparam int unsigned CursorW = 32;
  localparam int unsigned OpW     = CodeW + LenW;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_TRIM_START = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_TRIM_END   = 1'b1;

  // cigar operation codes that consume query
  localparam logic [CodeW-1:0] OP_M  = 4'd0;
  localparam logic [CodeW-1:0] OP_I  = 4'd1;
  localparam logic [CodeW-1:0] OP_S  = 4'd4;
  localparam logic [CodeW-1:0] OP_EQ = 4'd7;
  localparam logic [CodeW-1:0] OP_X  = 4'd8;

  // one packed cigar operation
  typedef struct packed {
    logic [LenW-1:0]  length;
    logic [CodeW-1:0] code;
  } op_t;

  // operation handed from the window unit to the sequencer
  typedef struct packed {
    logic keep;
    op_t  op;
  } kept_t;

  // one result item
  typedef struct packed {
    op_t  op;
    logic valid;
    logic eoc;
    logic ovf;
  } res_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_KEEP,
    S_FLUSH,
    S_LAST
  } state_e;

  // query-consuming operation test
  function automatic logic eats_query(input logic [CodeW-1:0] code);
    return code inside {OP_M, OP_I, OP_S, OP_EQ, OP_X};
  endfunction

endpackage

FILE: rtl/core/cqit_op_if.sv
// cqit_op_if: request channel carrying one input cigar operation
// depends on cqit_pkg for field widths
interface cqit_op_if;
  logic                        valid;
  logic                        ready;
  logic [cqit_pkg::CodeW-1:0]  op_code;
  logic [cqit_pkg::LenW-1:0]   op_length;
  logic                        last_op;

  modport source (output valid, output op_code, output op_length, output last_op,
                  input ready);
  modport sink (input valid, input op_code, input op_length, input last_op,
                output ready);
endinterface

FILE: rtl/core/cqit_res_if.sv
// cqit_res_if: request channel carrying one trimmed cigar result item
// depends on cqit_pkg for field widths
interface cqit_res_if;
  logic                        valid;
  logic                        ready;
  logic [cqit_pkg::CodeW-1:0]  out_code;
  logic [cqit_pkg::LenW-1:0]   out_length;
  logic                        out_valid;
  logic                        end_of_cigar;
  logic                        pending_overflow;

  modport source (output valid, output out_code, output out_length, output out_valid,
                  output end_of_cigar, output pending_overflow, input ready);
  modport sink (input valid, input out_code, input out_length, input out_valid,
                input end_of_cigar, input pending_overflow, output ready);
endinterface

FILE: rtl/core/cqit_ram.sv
// cqit_ram: generic single-write, single-read synchronous ram, registered read data
// depends on nothing
module cqit_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/core/cqit_window.sv
// cqit_window: query cursor and interval decision for one operation
// depends on cqit_pkg
module cqit_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic [cqit_pkg::CodeW-1:0]    code_i,
  input  logic [cqit_pkg::LenW-1:0]     length_i,
  input  logic                          decide_i,
  input  logic                          clear_i,
  input  logic [cqit_pkg::RegW-1:0]     trim_start_i,
  input  logic [cqit_pkg::RegW-1:0]     trim_end_i,
  output cqit_pkg::kept_t               kept_o
);
  logic [cqit_pkg::CursorW-1:0] cursor_q, cursor_d;
  logic [cqit_pkg::CursorW-1:0] prev_q;
  logic                         inside_q, inside_d;
  logic                         finished_q, finished_d;
  logic [cqit_pkg::CodeW-1:0]   code_q;
  logic [cqit_pkg::LenW-1:0]    len_q;
  cqit_pkg::kept_t              kept_q, kept_d;

  logic [cqit_pkg::CursorW:0]   sum;
  logic [cqit_pkg::CursorW-1:0] start_w, end_w;
  logic [cqit_pkg::CursorW-1:0] nl_in, nl_out, enter_len;
  logic                         past_end, entering;
  logic [cqit_pkg::LenW-1:0]    nl;

  assign start_w = {1'b0, trim_start_i};
  assign end_w   = {1'b0, trim_end_i};

  // saturating cursor advance
  assign sum = {1'b0, cursor_q} + (cqit_pkg::CursorW + 1)'(length_i);

  always_comb begin
    cursor_d = cursor_q;
    if (!finished_q && cqit_pkg::eats_query(code_i)) begin
      cursor_d = sum[cqit_pkg::CursorW] ? '1 : sum[cqit_pkg::CursorW-1:0];
    end
  end

  // interval decision on the advanced cursor
  assign past_end  = cursor_q > end_w;
  assign entering  = (cursor_q > start_w) && !inside_q;
  assign nl_in     = (end_w >= prev_q) ? end_w - prev_q : '0;
  assign nl_out    = (end_w >= start_w) ? end_w - start_w : '0;
  assign enter_len = cursor_q - start_w;
  assign nl        = inside_q ? nl_in[cqit_pkg::LenW-1:0] : nl_out[cqit_pkg::LenW-1:0];

  always_comb begin
    kept_d        = '0;
    kept_d.op.code = code_q;
    inside_d      = inside_q;
    finished_d    = finished_q;
    if (!finished_q) begin
      if (past_end) begin
        kept_d.keep      = (nl != '0);
        kept_d.op.length = nl;
        finished_d       = 1'b1;
      end else if (entering) begin
        kept_d.keep      = 1'b1;
        kept_d.op.length = enter_len[cqit_pkg::LenW-1:0];
        inside_d         = 1'b1;
      end else if (inside_q) begin
        kept_d.keep      = 1'b1;
        kept_d.op.length = len_q;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q   <= '0;
      prev_q     <= '0;
      inside_q   <= 1'b0;
      finished_q <= 1'b0;
      kept_q     <= '0;
    end else if (clear_i) begin
      cursor_q   <= '0;
      prev_q     <= '0;
      inside_q   <= 1'b0;
      finished_q <= 1'b0;
      kept_q     <= '0;
    end else if (load_i) begin
      prev_q   <= cursor_q;
      cursor_q <= cursor_d;
    end else if (decide_i) begin
      inside_q   <= inside_d;
      finished_q <= finished_d;
      kept_q     <= kept_d;
    end
  end

  // operation payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      code_q <= code_i;
      len_q  <= length_i;
    end
  end

  assign kept_o = kept_q;
endmodule

FILE: rtl/core/cigar_query_interval_trim_core.sv
// Flow: a request is taken in idle, its decision is registered in the decide state, and an
// item it releases is loaded into the result register from the keep state; the closing item
// follows from the last state. A new request is taken only back in idle, after any flush of
// held operations from the pending ram (one read per cycle while the result register is free).
// Reset (async, active low) clears the cursor, held tail, pending count, overflow flag and
// both trim registers; no clearing pass.
// depends on cqit_pkg, cqit_op_if, cqit_res_if, cqit_ram, cqit_window
module cigar_query_interval_trim_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cqit_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cqit_pkg::RegW-1:0]    cfg_wdata_i,
  cqit_op_if.sink                      op_in,
  cqit_res_if.source                   res_out
);
  localparam int unsigned IdxW = cqit_pkg::PendIdxW;
  localparam int unsigned CntW = cqit_pkg::PendCntW;

  cqit_pkg::state_e         state_q, state_d;
  logic [cqit_pkg::RegW-1:0] trim_start_q, trim_end_q;
  logic                     last_q, last_d;
  cqit_pkg::op_t            tail_q, tail_d;
  logic                     tail_valid_q, tail_valid_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [CntW-1:0]          flush_idx_q, flush_idx_d, flush_next;
  logic                     overflow_q, overflow_d;
  logic                     out_valid_q, out_valid_d;
  cqit_pkg::res_t           out_q, out_d;
  logic                     load_out, slot_free;

  logic                     win_load, win_decide, win_clear;
  cqit_pkg::kept_t          kept;
  cqit_pkg::state_e         next_state;

  logic                     ram_we, ram_re;
  logic [IdxW-1:0]          ram_raddr;
  logic [cqit_pkg::OpW-1:0] ram_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_start_q <= '0;
      trim_end_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cqit_pkg::REG_TRIM_START: trim_start_q <= cfg_wdata_i;
        cqit_pkg::REG_TRIM_END:   trim_end_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // cursor and interval decision
  cqit_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (win_load),
    .code_i       (op_in.op_code),
    .length_i     (op_in.op_length),
    .decide_i     (win_decide),
    .clear_i      (win_clear),
    .trim_start_i (trim_start_q),
    .trim_end_i   (trim_end_q),
    .kept_o       (kept)
  );

  // pending non-query operations
  cqit_ram #(
    .Width (cqit_pkg::OpW),
    .Depth (cqit_pkg::PENDING_DEPTH)
  ) u_pending (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (kept.op),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign slot_free   = !out_valid_q || res_out.ready;
  assign next_state  = last_q ? cqit_pkg::S_LAST : cqit_pkg::S_IDLE;
  assign flush_next  = flush_idx_q + CntW'(1);
  assign op_in.ready = (state_q == cqit_pkg::S_IDLE);

  // sequencer: next state and datapath control
  always_comb begin
    state_d      = state_q;
    last_d       = last_q;
    tail_d       = tail_q;
    tail_valid_d = tail_valid_q;
    count_d      = count_q;
    flush_idx_d  = flush_idx_q;
    overflow_d   = overflow_q;
    out_d        = out_q;
    load_out     = 1'b0;
    win_load     = 1'b0;
    win_decide   = 1'b0;
    win_clear    = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = flush_next[IdxW-1:0];
    case (state_q)
      cqit_pkg::S_IDLE: begin
        if (op_in.valid) begin
          win_load = 1'b1;
          last_d   = op_in.last_op;
          state_d  = cqit_pkg::S_DECIDE;
        end
      end
      cqit_pkg::S_DECIDE: begin
        win_decide = 1'b1;
        state_d    = cqit_pkg::S_KEEP;
      end
      cqit_pkg::S_KEEP: begin
        if (!kept.keep) begin
          state_d = next_state;
        end else if (!tail_valid_q) begin
          tail_d       = kept.op;
          tail_valid_d = 1'b1;
          state_d      = next_state;
        end else if (cqit_pkg::eats_query(kept.op.code)) begin
          // release the held tail, then the pending ops
          if (slot_free) begin
            load_out = 1'b1;
            out_d    = '{op: tail_q, valid: 1'b1, eoc: 1'b0, ovf: overflow_q};
            tail_d   = kept.op;
            if (count_q != '0) begin
              ram_re      = 1'b1;
              ram_raddr   = '0;
              flush_idx_d = '0;
              state_d     = cqit_pkg::S_FLUSH;
            end else begin
              state_d = next_state;
            end
          end
        end else if (count_q < CntW'(cqit_pkg::PENDING_DEPTH)) begin
          ram_we  = 1'b1;
          count_d = count_q + CntW'(1);
          state_d = next_state;
        end else begin
          overflow_d = 1'b1;
          state_d    = next_state;
        end
      end
      cqit_pkg::S_FLUSH: begin
        if (slot_free) begin
          load_out = 1'b1;
          out_d    = '{op: cqit_pkg::op_t'(ram_rdata), valid: 1'b1, eoc: 1'b0,
                       ovf: overflow_q};
          if (flush_next == count_q) begin
            count_d = '0;
            state_d = next_state;
          end else begin
            flush_idx_d = flush_next;
            ram_re      = 1'b1;
          end
        end
      end
      cqit_pkg::S_LAST: begin
        // close the cigar: tail with end mark, or an empty item
        if (slot_free) begin
          load_out = 1'b1;
          if (tail_valid_q) begin
            out_d = '{op: tail_q, valid: 1'b1, eoc: 1'b1, ovf: overflow_q};
          end else begin
            out_d = '{op: '0, valid: 1'b0, eoc: 1'b1, ovf: overflow_q};
          end
          tail_valid_d = 1'b0;
          count_d      = '0;
          overflow_d   = 1'b0;
          win_clear    = 1'b1;
          state_d      = cqit_pkg::S_IDLE;
        end
      end
      default: state_d = cqit_pkg::S_IDLE;
    endcase
  end

  // result register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (res_out.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cqit_pkg::S_IDLE;
      last_q       <= 1'b0;
      tail_valid_q <= 1'b0;
      count_q      <= '0;
      flush_idx_q  <= '0;
      overflow_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      last_q       <= last_d;
      tail_valid_q <= tail_valid_d;
      count_q      <= count_d;
      flush_idx_q  <= flush_idx_d;
      overflow_q   <= overflow_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tail_q <= tail_d;
    out_q  <= out_d;
  end

  assign res_out.valid            = out_valid_q;
  assign res_out.out_code         = out_q.op.code;
  assign res_out.out_length       = out_q.op.length;
  assign res_out.out_valid        = out_q.valid;
  assign res_out.end_of_cigar     = out_q.eoc;
  assign res_out.pending_overflow = out_q.ovf;

`ifndef SYNTH
  // pending count stays within the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(cqit_pkg::PENDING_DEPTH))
    else $error("pending count beyond store depth");

  // a result is never loaded over one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || res_out.ready))
    else $error("result register overwritten");

  // flush reads only filled entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cqit_pkg::S_FLUSH) |-> (flush_idx_q < count_q))
    else $error("flush index past pending count");

  // closing the cigar leaves a clean run state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cqit_pkg::S_LAST && slot_free) |=>
      (state_q == cqit_pkg::S_IDLE && count_q == '0 && !tail_valid_q && !overflow_q))
    else $error("run state not cleared at end of cigar");
`endif
endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for cigar_query_interval_trim_core, directed table then random cigars
// depends on cqit_pkg, cqit_op_if, cqit_res_if and the core; holds its own trimming predictor
module tb;

  // non-query operation codes, and the first of the unassigned codes 9..15
  localparam logic [cqit_pkg::CodeW-1:0] OP_D     = 4'd2;
  localparam logic [cqit_pkg::CodeW-1:0] OP_N     = 4'd3;
  localparam logic [cqit_pkg::CodeW-1:0] OP_H     = 4'd5;
  localparam logic [cqit_pkg::CodeW-1:0] OP_P     = 4'd6;
  localparam logic [cqit_pkg::CodeW-1:0] OP_UNDEF = 4'd9;

  localparam logic [cqit_pkg::RegW-1:0] REG_MAX = {cqit_pkg::RegW{1'b1}};
  localparam logic [cqit_pkg::LenW-1:0] LEN_MAX = {cqit_pkg::LenW{1'b1}};

  // settle after the last result, long hold-off of the sink, and no-progress limit
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 5000;

  logic clk;
  logic rst_n;
  logic                          cfg_we;
  logic [cqit_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [cqit_pkg::RegW-1:0]     cfg_wdata;

  cqit_op_if  op_ch ();
  cqit_res_if res_ch ();

  cigar_query_interval_trim_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .op_in       (op_ch),
    .res_out     (res_ch)
  );

  // clock and the single reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // trimming predictor
  // ---------------------------------------------------------------------------
  logic [cqit_pkg::RegW-1:0]    keep_from;
  logic [cqit_pkg::RegW-1:0]    keep_to;
  logic [cqit_pkg::CursorW-1:0] qry_pos;
  logic                         in_span;
  logic                         span_done;
  cqit_pkg::op_t                tail_hold;
  logic                         tail_live;
  cqit_pkg::op_t                side_ops [cqit_pkg::PENDING_DEPTH];
  int unsigned                  side_cnt;
  logic                         side_ovf;

  cqit_pkg::res_t step_out [$];
  cqit_pkg::res_t trimmed_q [$];

  int unsigned mismatch_cnt;
  int unsigned sent_cnt;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  bit          hold_off;

  function automatic logic consumes_query(input logic [cqit_pkg::CodeW-1:0] code);
    return code inside {cqit_pkg::OP_M, cqit_pkg::OP_I, cqit_pkg::OP_S, cqit_pkg::OP_EQ,
                        cqit_pkg::OP_X};
  endfunction

  function automatic void clear_cigar();
    qry_pos   = '0;
    in_span   = 1'b0;
    span_done = 1'b0;
    tail_hold = '0;
    tail_live = 1'b0;
    side_cnt  = 0;
    side_ovf  = 1'b0;
  endfunction

  function automatic void emit_res(input cqit_pkg::op_t o, input logic vld, input logic eoc);
    cqit_pkg::res_t r;
    r.op    = o;
    r.valid = vld;
    r.eoc   = eoc;
    r.ovf   = side_ovf;
    step_out = {step_out, r};
  endfunction

  // tail is held back; a query op flushes tail and pending non-query ops
  function automatic void keep_trimmed(input logic [cqit_pkg::CodeW-1:0] code,
                                       input logic [cqit_pkg::LenW-1:0] len);
    cqit_pkg::op_t o;
    o.code   = code;
    o.length = len;
    if (!tail_live) begin
      tail_hold = o;
      tail_live = 1'b1;
    end else if (consumes_query(code)) begin
      emit_res(tail_hold, 1'b1, 1'b0);
      for (int i = 0; i < side_cnt; i++) emit_res(side_ops[i], 1'b1, 1'b0);
      side_cnt  = 0;
      tail_hold = o;
    end else if (side_cnt < cqit_pkg::PENDING_DEPTH) begin
      side_ops[side_cnt] = o;
      side_cnt++;
    end else begin
      side_ovf = 1'b1;
    end
  endfunction

  function automatic void trim_step(input logic [cqit_pkg::CodeW-1:0] code,
                                    input logic [cqit_pkg::LenW-1:0] len,
                                    input logic last);
    logic [cqit_pkg::CursorW-1:0] prev;
    logic [cqit_pkg::CursorW:0]   sum;
    logic [cqit_pkg::CursorW-1:0] cut;
    step_out.delete();
    if (!span_done) begin
      prev = qry_pos;
      if (consumes_query(code)) begin
        sum     = {1'b0, qry_pos} + (cqit_pkg::CursorW + 1)'(len);
        qry_pos = sum[cqit_pkg::CursorW] ? {cqit_pkg::CursorW{1'b1}}
                                         : sum[cqit_pkg::CursorW-1:0];
      end
      if (qry_pos > {1'b0, keep_to}) begin
        // op crossing the end of the interval
        if (in_span) cut = ({1'b0, keep_to} >= prev) ? {1'b0, keep_to} - prev : '0;
        else cut = (keep_to >= keep_from) ? {1'b0, keep_to} - {1'b0, keep_from} : '0;
        if (cut[cqit_pkg::LenW-1:0] != '0) keep_trimmed(code, cut[cqit_pkg::LenW-1:0]);
        span_done = 1'b1;
      end else if (qry_pos > {1'b0, keep_from} && !in_span) begin
        // op straddling the start
        in_span = 1'b1;
        cut     = qry_pos - {1'b0, keep_from};
        keep_trimmed(code, cut[cqit_pkg::LenW-1:0]);
      end else if (in_span) begin
        keep_trimmed(code, len);
      end
    end
    if (last) begin
      if (tail_live) emit_res(tail_hold, 1'b1, 1'b1);
      else emit_res('0, 1'b0, 1'b1);
      clear_cigar();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin : check_res
    cqit_pkg::res_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (trimmed_q.size() == 0) begin
        report_mismatch("unrequested result", {res_ch.out_length, res_ch.out_code}, '0);
      end else begin
        want = trimmed_q.pop_front();
        if (res_ch.out_code !== want.op.code)
          report_mismatch("out_code", 32'(res_ch.out_code), 32'(want.op.code));
        if (res_ch.out_length !== want.op.length)
          report_mismatch("out_length", 32'(res_ch.out_length), 32'(want.op.length));
        if (res_ch.out_valid !== want.valid)
          report_mismatch("out_valid", 32'(res_ch.out_valid), 32'(want.valid));
        if (res_ch.end_of_cigar !== want.eoc)
          report_mismatch("end_of_cigar", 32'(res_ch.end_of_cigar), 32'(want.eoc));
        if (res_ch.pending_overflow !== want.ovf)
          report_mismatch("pending_overflow", 32'(res_ch.pending_overflow), 32'(want.ovf));
      end
    end
  end

  // watchdog: cycles without any request moving on either side
  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if (!rst_n || (op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("watchdog: no progress, %0d results still due", trimmed_q.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sink: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : sink_proc
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        res_ch.ready <= 1'b0;
        for (int k = 1; k < HOLD_CYCLES; k++) @(negedge clk);
        hold_off = 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // source side
  // ---------------------------------------------------------------------------
  task automatic send_op(input logic [cqit_pkg::CodeW-1:0] code,
                         input logic [cqit_pkg::LenW-1:0] len,
                         input logic last, input bit typed, input cqit_pkg::res_t typed_res);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      op_ch.valid <= 1'b0;
      @(negedge clk);
    end
    op_ch.valid     <= 1'b1;
    op_ch.op_code   <= code;
    op_ch.op_length <= len;
    op_ch.last_op   <= last;
    do @(posedge clk); while (!op_ch.ready);
    trim_step(code, len, last);
    if (typed) trimmed_q = {trimmed_q, typed_res};
    else foreach (step_out[i]) trimmed_q = {trimmed_q, step_out[i]};
    sent_cnt++;
  endtask

  // drop valid, wait for every due result, then let the core settle
  task automatic quiesce();
    @(negedge clk);
    op_ch.valid <= 1'b0;
    while (trimmed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cqit_pkg::CfgIdxW-1:0] idx,
                           input logic [cqit_pkg::RegW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == cqit_pkg::REG_TRIM_START) keep_from = val;
    else keep_to = val;
  endtask

  function automatic logic [cqit_pkg::CodeW-1:0] pick_side_code();
    if ($urandom_range(0, 99) < 30) return OP_UNDEF + cqit_pkg::CodeW'($urandom_range(0, 6));
    case ($urandom_range(0, 3))
      0: return OP_D;
      1: return OP_N;
      2: return OP_H;
      default: return OP_P;
    endcase
  endfunction

  function automatic logic [cqit_pkg::CodeW-1:0] pick_code();
    if ($urandom_range(0, 99) < 40) return pick_side_code();
    case ($urandom_range(0, 4))
      0: return cqit_pkg::OP_M;
      1: return cqit_pkg::OP_I;
      2: return cqit_pkg::OP_S;
      3: return cqit_pkg::OP_EQ;
      default: return cqit_pkg::OP_X;
    endcase
  endfunction

  function automatic logic [cqit_pkg::LenW-1:0] pick_len(input bit wide);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (wide || r < 8) return cqit_pkg::LenW'($urandom());
    if (r < 25) return cqit_pkg::LenW'($urandom_range(0, 3));
    return cqit_pkg::LenW'($urandom_range(0, 40));
  endfunction

  // one random cigar; some carry a run of non-query ops long enough to fill or overflow the store
  task automatic send_cigar(input bit wide);
    int unsigned n;
    int unsigned run;
    logic [cqit_pkg::CodeW-1:0] code;
    n   = wide ? $urandom_range(4, 20) : $urandom_range(1, 14);
    run = ($urandom_range(0, 99) < 12) ? $urandom_range(8, 11) : 0;
    if (run != 0) n = n + run + 1;
    for (int k = 0; k < n; k++) begin
      if (k >= 1 && k <= run) code = pick_side_code();
      else code = pick_code();
      send_op(code, pick_len(wide), k == n - 1, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    bit                           is_cfg;
    logic [cqit_pkg::CfgIdxW-1:0] idx;
    logic [cqit_pkg::RegW-1:0]    val;
    logic [cqit_pkg::CodeW-1:0]   code;
    logic [cqit_pkg::LenW-1:0]    len;
    logic                         last;
    bit                           typed;
    cqit_pkg::res_t               res;
  } plan_row_t;

  plan_row_t plan_q [$];

  function automatic void plan_cfg(input logic [cqit_pkg::CfgIdxW-1:0] idx,
                                   input logic [cqit_pkg::RegW-1:0] val);
    plan_row_t r;
    r        = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    plan_q   = {plan_q, r};
  endfunction

  function automatic void plan_op(input logic [cqit_pkg::CodeW-1:0] code,
                                  input logic [cqit_pkg::LenW-1:0] len,
                                  input logic last);
    plan_row_t r;
    r      = '{default: '0};
    r.code = code;
    r.len  = len;
    r.last = last;
    plan_q = {plan_q, r};
  endfunction

  function automatic void plan_chk(input logic [cqit_pkg::CodeW-1:0] code,
                                   input logic [cqit_pkg::LenW-1:0] len,
                                   input logic last, input logic [cqit_pkg::CodeW-1:0] want_code,
                                   input logic [cqit_pkg::LenW-1:0] want_len,
                                   input logic want_vld);
    plan_row_t r;
    r              = '{default: '0};
    r.code         = code;
    r.len          = len;
    r.last         = last;
    r.typed        = 1'b1;
    r.res.op.code  = want_code;
    r.res.op.length = want_len;
    r.res.valid    = want_vld;
    r.res.eoc      = 1'b1;
    r.res.ovf      = 1'b0;
    plan_q         = {plan_q, r};
  endfunction

  function automatic void build_plan();
    // after reset the interval is empty: any op gives the empty result
    plan_chk(cqit_pkg::OP_M, 28'd5, 1'b1, cqit_pkg::OP_M, '0, 1'b0);
    // widest interval: full-length op, held ops released, store overflow
    plan_cfg(cqit_pkg::REG_TRIM_START, '0);
    plan_cfg(cqit_pkg::REG_TRIM_END, REG_MAX);
    plan_op(OP_H, 28'd3, 1'b0);
    plan_op(cqit_pkg::OP_S, LEN_MAX, 1'b0);
    plan_op(OP_D, 28'd7, 1'b0);
    plan_op(cqit_pkg::OP_I, 28'd0, 1'b0);
    plan_op(OP_N, 28'd1, 1'b0);
    plan_op(OP_P, 28'd2, 1'b0);
    for (int c = 0; c < 7; c++) plan_op(OP_UNDEF + cqit_pkg::CodeW'(c), LEN_MAX, 1'b0);
    plan_op(cqit_pkg::OP_X, 28'd4, 1'b1);
    // one op straddling both ends
    plan_cfg(cqit_pkg::REG_TRIM_START, 31'd10);
    plan_cfg(cqit_pkg::REG_TRIM_END, 31'd20);
    plan_chk(cqit_pkg::OP_M, 28'd25, 1'b1, cqit_pkg::OP_M, 28'd10, 1'b1);
    // clipped start, pending op released, shortened end, ops after the end ignored
    plan_op(cqit_pkg::OP_EQ, 28'd12, 1'b0);
    plan_op(OP_D, 28'd3, 1'b0);
    plan_op(cqit_pkg::OP_X, 28'd100, 1'b0);
    plan_op(cqit_pkg::OP_M, 28'd5, 1'b1);
    // inverted interval: nothing kept
    plan_cfg(cqit_pkg::REG_TRIM_START, 31'd20);
    plan_cfg(cqit_pkg::REG_TRIM_END, 31'd10);
    plan_chk(cqit_pkg::OP_M, 28'd15, 1'b1, cqit_pkg::OP_M, '0, 1'b0);
    // zero-length end op is dropped, and the pending op behind the tail with it
    plan_cfg(cqit_pkg::REG_TRIM_START, 31'd10);
    plan_cfg(cqit_pkg::REG_TRIM_END, 31'd20);
    plan_op(cqit_pkg::OP_M, 28'd10, 1'b0);
    plan_op(cqit_pkg::OP_M, 28'd10, 1'b0);
    plan_op(OP_D, 28'd2, 1'b0);
    plan_op(cqit_pkg::OP_I, 28'd5, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stim
    logic [cqit_pkg::RegW-1:0] lo;
    logic [cqit_pkg::RegW-1:0] hi;
    int unsigned               goal;
    op_ch.valid     = 1'b0;
    op_ch.op_code   = '0;
    op_ch.op_length = '0;
    op_ch.last_op   = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    keep_from       = '0;
    keep_to         = '0;
    mismatch_cnt    = 0;
    sent_cnt        = 0;
    hold_off        = 1'b0;
    src_idle_pct    = 25;
    sink_idle_pct   = 74;
    clear_cigar();
    build_plan();
    @(posedge rst_n);
    repeat (2) @(posedge clk);

    foreach (plan_q[i]) begin
      if (plan_q[i].is_cfg) begin
        quiesce();
        write_reg(plan_q[i].idx, plan_q[i].val);
      end else begin
        send_op(plan_q[i].code, plan_q[i].len, plan_q[i].last, plan_q[i].typed,
                plan_q[i].res);
      end
    end

    // random phases: sink idles, then source idles, then neither
    for (int ph = 0; ph < 6; ph++) begin
      src_idle_pct  = (ph < 2) ? 25 : (ph < 4) ? 74 : 0;
      sink_idle_pct = (ph < 2) ? 74 : (ph < 4) ? 25 : 0;
      case (ph)
        0: begin
          lo = cqit_pkg::RegW'($urandom_range(0, 20));
          hi = lo + cqit_pkg::RegW'($urandom_range(10, 150));
        end
        1: begin
          lo = cqit_pkg::RegW'($urandom_range(0, 60));
          hi = cqit_pkg::RegW'($urandom_range(0, 60));
        end
        2: begin
          lo = '0;
          hi = cqit_pkg::RegW'($urandom_range(20, 300));
        end
        3: begin
          lo = cqit_pkg::RegW'($urandom_range(100, 300));
          hi = REG_MAX;
        end
        4: begin
          lo = cqit_pkg::RegW'($urandom_range(0, 50));
          hi = lo + cqit_pkg::RegW'(100);
        end
        default: begin
          lo = cqit_pkg::RegW'($urandom_range(0, 32'h4000_0000));
          hi = $urandom_range(0, 1) ? REG_MAX
                                    : lo + cqit_pkg::RegW'($urandom_range(0, 32'h4000_0000));
        end
      endcase
      quiesce();
      write_reg(cqit_pkg::REG_TRIM_START, lo);
      write_reg(cqit_pkg::REG_TRIM_END, hi);
      // sink holds off while the source keeps offering
      if (ph == 4) hold_off = 1'b1;
      goal = sent_cnt + 53;
      while (sent_cnt < goal) send_cigar(ph == 5);
    end

    quiesce();
    if (mismatch_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
